FILE: rtl/med_golomb_rice_plane_encoder_assert.svh
// assertion macros used by the encoder's code queue
`ifndef MED_GOLOMB_RICE_PLANE_ENCODER_ASSERT_SVH
`define MED_GOLOMB_RICE_PLANE_ENCODER_ASSERT_SVH

// condition must never hold at a clock edge
`define MGRPE_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mgrpe: forbidden condition seen");

// consequence must hold in the cycle after the antecedent
`define MGRPE_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mgrpe: sequence check failed");

`endif

FILE: rtl/mgrpe_pkg.sv
// shared types and constants of the plane encoder
package mgrpe_pkg;

  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam logic [1:0] IDX_WIDTH  = 2'd0;
  localparam logic [1:0] IDX_HEIGHT = 2'd1;

  localparam logic [15:0] AVG_INIT    = 16'd1024;
  localparam logic [19:0] DIV10_RECIP = 20'd838861;
  localparam logic [8:0]  ESC_Q_MAX   = 9'd30;
  localparam logic [5:0]  ESC_LEN     = 6'd48;

  localparam logic [19:0] K_THRESH [12] = '{
    20'd251, 20'd502, 20'd1004, 20'd2008, 20'd4015, 20'd8029,
    20'd16057, 20'd32113, 20'd64226, 20'd128451, 20'd256902, 20'd513803
  };

  typedef struct packed {
    logic [8:0] v;
    logic [3:0] k;
    logic       esc;
    logic       eop;
  } code_t;

endpackage

FILE: rtl/mgrpe_ram.sv
// generic one-write two-read ram with registered read data
module mgrpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rda_q, rdb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rda_q <= mem_q[raddr_a_i];
      rdb_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rda_q;
  assign rdata_b_o = rdb_q;

endmodule

FILE: rtl/mgrpe_front.sv
// front end: position, prediction, context, k and average update
module mgrpe_front #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned CONTEXTS  = 64,
  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1),
  localparam int unsigned AW  = $clog2(MAX_WIDTH),
  localparam int unsigned CXW = $clog2(CONTEXTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  logic [CW-1:0]         width_i,
  input  logic [12:0]           height_i,
  input  logic                  pixel_valid_i,
  input  logic [7:0]            pixel_i,
  output logic                  pixel_stall_o,
  output logic                  push_o,
  output mgrpe_pkg::code_t      code_o,
  input  logic                  full_i
);

  // position counters
  logic [CW-1:0] col_q, col_d;
  logic [12:0]   row_q, row_d;
  logic          col_last, row_last, accept;

  // stage 1: accepted pixel, line store read in flight
  logic          s1_vld_q;
  logic [7:0]    s1_px_q;
  logic [CW-1:0] s1_col_q;
  logic          s1_row0_q, s1_colz_q, s1_dok_q, s1_fwdb_q, s1_fwdd_q, s1_eop_q;
  logic          s1_adv;

  // stage 2: classified pixel
  logic           s2_vld_q;
  logic [CXW-1:0] s2_ctx_q;
  logic [8:0]     s2_v_q;
  logic [7:0]     s2_mag_q;
  logic           s2_eop_q;

  logic [7:0] prev_px_q, prev_b_q;
  logic [7:0] rd_b, rd_d;
  logic [AW-1:0] raddr_d;

  // averages live in a ram read on the classify edge, valid bits mark written entries
  logic [CONTEXTS-1:0] avg_ok_q;
  logic [15:0] avg_rd, avg_rd_b, avg_fwd_q, avg_new;
  logic        avg_hit_q;

  // stage 1 combinational
  logic [7:0] a, b, c, d, b_up, d_up, mn, mx, pred;
  logic [9:0] g;
  logic [17:0] p5, p10, p20;
  logic [5:0] r;
  logic [CXW-1:0] ctx;
  logic signed [9:0] diff;
  logic [7:0] mag;
  logic [8:0] v;

  // stage 2 combinational
  logic [15:0] old;
  logic [3:0]  k;
  logic [8:0]  qf;
  logic [19:0] x;
  logic [39:0] prod;
  logic        s2_adv;

  assign col_last = ({1'b0, col_q} + 1'b1) == {1'b0, width_i};
  assign row_last = (row_q + 13'd1) == height_i;
  assign s2_adv   = !full_i;
  assign s1_adv   = s1_vld_q && (!s2_vld_q || s2_adv);
  assign pixel_stall_o = s1_vld_q && !s1_adv;
  assign accept   = pixel_valid_i && !pixel_stall_o;
  assign raddr_d  = col_last ? col_q[AW-1:0] : AW'(col_q + 1'b1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? 13'd0 : row_q + 13'd1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  mgrpe_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i     (clk_i),
    .we_i      (s1_adv),
    .waddr_i   (s1_col_q[AW-1:0]),
    .wdata_i   (s1_px_q),
    .re_i      (accept),
    .raddr_a_i (col_q[AW-1:0]),
    .raddr_b_i (raddr_d),
    .rdata_a_o (rd_b),
    .rdata_b_o (rd_d)
  );

  mgrpe_ram #(.WIDTH(16), .DEPTH(CONTEXTS)) u_avg (
    .clk_i     (clk_i),
    .we_i      (push_o),
    .waddr_i   (s2_ctx_q),
    .wdata_i   (avg_new),
    .re_i      (s1_adv),
    .raddr_a_i (ctx),
    .raddr_b_i (ctx),
    .rdata_a_o (avg_rd),
    .rdata_b_o (avg_rd_b)
  );

  // neighbours, with forwarding of the pixel written on the read edge
  always_comb begin
    b_up = s1_fwdb_q ? prev_px_q : rd_b;
    d_up = s1_fwdd_q ? prev_px_q : rd_d;
    a = s1_colz_q ? 8'd0 : prev_px_q;
    b = s1_row0_q ? 8'd0 : b_up;
    c = (s1_row0_q || s1_colz_q) ? 8'd0 : prev_b_q;
    d = s1_dok_q ? d_up : b;

    mn = (a < b) ? a : b;
    mx = (a > b) ? a : b;
    if (c >= mx) begin
      pred = mn;
    end else if (c <= mn) begin
      pred = mx;
    end else begin
      pred = 8'(({1'b0, a} + {1'b0, b}) - {1'b0, c});
    end

    diff = $signed({2'b00, s1_px_q}) - $signed({2'b00, pred});
    if (diff > 10'sd128) begin
      diff = diff - 10'sd256;
    end else if (diff < -10'sd128) begin
      diff = diff + 10'sd256;
    end
    mag = diff[9] ? 8'(-diff) : diff[7:0];
    v   = diff[9] ? ({mag, 1'b0} - 9'd1) : {mag, 1'b0};

    g = 10'((a > c) ? a - c : c - a) + 10'((b > c) ? b - c : c - b)
      + 10'((d > b) ? d - b : b - d);
    // divides by 5, 10 and 20 as reciprocal multiplies, exact below 1024
    p5  = 18'(g - 10'd25) * 18'd205;
    p10 = 18'(g - 10'd40) * 18'd205;
    p20 = 18'(g - 10'd100) * 18'd205;
    if (g < 10'd3) begin
      r = 6'd0;
    end else if (g < 10'd8) begin
      r = 6'd1;
    end else if (g < 10'd15) begin
      r = 6'd2;
    end else if (g < 10'd25) begin
      r = 6'd3;
    end else if (g < 10'd40) begin
      r = 6'd4 + 6'(p5 >> 10);
    end else if (g < 10'd100) begin
      r = 6'd7 + 6'(p10 >> 11);
    end else begin
      r = 6'd13 + 6'(p20 >> 12);
    end
    ctx = (r > 6'(CONTEXTS - 1)) ? CXW'(CONTEXTS - 1) : r[CXW-1:0];
  end

  // k, escape test and running average update
  always_comb begin
    old = avg_ok_q[s2_ctx_q] ? (avg_hit_q ? avg_fwd_q : avg_rd) : mgrpe_pkg::AVG_INIT;
    k = 4'd0;
    for (int j = 0; j < 12; j++) begin
      if ({4'b0, old} >= mgrpe_pkg::K_THRESH[j]) begin
        k = k + 4'd1;
      end
    end
    qf = s2_v_q >> k;
    x = ({4'b0, old} << 3) + {4'b0, old} + {4'b0, s2_mag_q, 8'b0} + 20'd5;
    prod = {20'b0, x} * {20'b0, mgrpe_pkg::DIV10_RECIP};
  end

  assign avg_new    = prod[38:23];
  assign push_o     = s2_vld_q && s2_adv;
  assign code_o.v   = s2_v_q;
  assign code_o.k   = k;
  assign code_o.esc = qf > mgrpe_pkg::ESC_Q_MAX;
  assign code_o.eop = s2_eop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      avg_ok_q <= '0;
    end else if (restart_i) begin
      col_q    <= '0;
      row_q    <= '0;
      avg_ok_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      s1_vld_q <= accept || (s1_vld_q && !s1_adv);
      s2_vld_q <= s1_adv || (s2_vld_q && !s2_adv);
      if (push_o) begin
        if (s2_eop_q) begin
          avg_ok_q <= '0;
        end else begin
          avg_ok_q[s2_ctx_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_col_q  <= col_q;
      s1_row0_q <= row_q == 13'd0;
      s1_colz_q <= col_q == '0;
      s1_dok_q  <= (row_q != 13'd0) && !col_last;
      s1_fwdb_q <= s1_adv && (s1_col_q == col_q);
      s1_fwdd_q <= s1_adv && ({1'b0, s1_col_q} == ({1'b0, col_q} + 1'b1));
      s1_eop_q  <= col_last && row_last;
    end
    if (s1_adv) begin
      prev_px_q <= s1_px_q;
      prev_b_q  <= b;
      s2_ctx_q  <= ctx;
      s2_v_q    <= v;
      s2_mag_q  <= mag;
      s2_eop_q  <= s1_eop_q;
      // average written on the same edge as the read is taken from the update
      avg_hit_q <= push_o && (s2_ctx_q == ctx);
      avg_fwd_q <= avg_new;
    end
  end

endmodule

FILE: rtl/mgrpe_fifo.sv
// short code queue between front and back end
`include "med_golomb_rice_plane_encoder_assert.svh"
module mgrpe_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mgrpe_pkg::code_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output mgrpe_pkg::code_t data_o,
  output logic             empty_o
);

  mgrpe_pkg::code_t mem_q [mgrpe_pkg::FIFO_DEPTH];
  logic [mgrpe_pkg::FIFO_AW-1:0] wp_q, rp_q;
  logic [mgrpe_pkg::FIFO_AW:0]   count_q;

  assign full_o  = count_q == (mgrpe_pkg::FIFO_AW + 1)'(mgrpe_pkg::FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  `MGRPE_NEVER(a_no_overflow, push_i && full_o)
  `MGRPE_NEVER(a_no_underflow, pop_i && empty_o)
  `MGRPE_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1)

endmodule

FILE: rtl/mgrpe_pack.sv
// back end: code assembly and msb-first byte packing
module mgrpe_pack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic             valid_i,
  input  mgrpe_pkg::code_t code_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             last_o,
  output logic             plane_end_o
);

  logic        busy_q, eop_q;
  logic [55:0] buf_q;
  logic [5:0]  rem_q;
  logic [7:0]  pend_q;
  logic [2:0]  pcnt_q;
  logic        out_vld_q, out_last_q, out_pe_q;
  logic [7:0]  out_byte_q;

  logic        slot_free, need_emit, emit, load, finish, last;
  logic [7:0]  src_pend;
  logic [2:0]  src_cnt;
  logic [4:0]  q5;
  logic [8:0]  vm;
  logic [47:0] code48;
  logic [5:0]  len, r2;
  logic [55:0] buf_new;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign need_emit = busy_q && ((rem_q >= 6'd8) || (eop_q && (rem_q != 6'd0)));
  assign emit      = need_emit && slot_free;
  assign load      = valid_i && (!busy_q || !need_emit);
  assign finish    = busy_q && !need_emit;
  assign pop_o     = load;

  always_comb begin
    src_pend = busy_q ? (eop_q ? 8'd0 : buf_q[55:48]) : pend_q;
    src_cnt  = busy_q ? (eop_q ? 3'd0 : rem_q[2:0]) : pcnt_q;
    q5 = 5'(code_i.v >> code_i.k);
    vm = code_i.v & 9'(((10'd1 << code_i.k) - 10'd1));
    if (code_i.esc) begin
      code48 = {31'h7FFF_FFFF, 1'b0, 7'b0, code_i.v};
      len    = mgrpe_pkg::ESC_LEN;
    end else begin
      code48 = ~(48'hFFFF_FFFF_FFFF >> q5)
             | ({39'b0, vm} << (6'd47 - {1'b0, q5} - {2'b0, code_i.k}));
      len    = {1'b0, q5} + 6'd1 + {2'b0, code_i.k};
    end
    buf_new = {src_pend, 48'b0} | ({code48, 8'b0} >> src_cnt);
    r2 = rem_q - 6'd8;
    if (rem_q >= 6'd8) begin
      last = (r2 == 6'd0) || ((r2 < 6'd8) && !eop_q);
    end else begin
      last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pend_q    <= '0;
      pcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (restart_i) begin
      busy_q <= 1'b0;
      pend_q <= '0;
      pcnt_q <= '0;
    end else begin
      if (slot_free) begin
        out_vld_q <= emit;
      end
      if (load) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
        pend_q <= src_pend;
        pcnt_q <= src_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= buf_q[55:48];
      out_last_q <= last;
      out_pe_q   <= eop_q && last;
      buf_q      <= buf_q << 8;
      rem_q      <= (rem_q >= 6'd8) ? r2 : 6'd0;
    end else if (load) begin
      buf_q <= buf_new;
      rem_q <= {3'b0, src_cnt} + len;
      eop_q <= code_i.eop;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign plane_end_o = out_pe_q;

endmodule

FILE: rtl/med_golomb_rice_plane_encoder.sv
// top level of the median-predicted golomb-rice plane encoder
//
// channel   direction  signals                                   transfer when
// pixel     in         pixel_valid_i, pixel_stall_o, pixel_i     valid and not stall
// code      out        out_valid_o, out_stall_i, out_byte_o,     valid and not stall
//                      last_o, plane_end_o
// config    in         cfg_we_i, cfg_index_i, cfg_data_i         write enable high
//
// a pixel passes the front end in a line store read and classify stage, then
// a k and context update stage; the front takes one pixel per cycle while
// pixel_stall_o is low, and the back end loads a code and then sends one byte
// per cycle while out_stall_i is low
// reset clears position, averages and pending bits; line store is not cleared
// a stall on the code side fills the four-entry queue and then stalls pixels
module med_golomb_rice_plane_encoder #(
  parameter int unsigned MAX_WIDTH = 4096,
  parameter int unsigned CONTEXTS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        pixel_valid_i,
  output logic        pixel_stall_o,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        plane_end_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);

  logic [12:0]   width_q, height_q;
  logic          restart;
  logic [31:0]   w32, h32;
  logic [CW-1:0] eff_width;
  logic [12:0]   eff_height;

  logic             push, full, pop, empty;
  mgrpe_pkg::code_t code_in, code_out;

  // a write to the width or height register restarts the plane
  assign restart = cfg_we_i && ((cfg_index_i == mgrpe_pkg::IDX_WIDTH)
                             || (cfg_index_i == mgrpe_pkg::IDX_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd1;
      height_q <= 13'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mgrpe_pkg::IDX_WIDTH:  width_q  <= cfg_data_i;
        mgrpe_pkg::IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, large values clamp to the store limits
  always_comb begin
    w32 = (width_q == 13'd0) ? 32'd1 : {19'd0, width_q};
    h32 = (height_q == 13'd0) ? 32'd1 : {19'd0, height_q};
    eff_width  = (w32 > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(w32);
    eff_height = (h32 > 32'(mgrpe_pkg::MAX_HEIGHT)) ? 13'(mgrpe_pkg::MAX_HEIGHT)
                                                    : 13'(h32);
  end

  mgrpe_front #(.MAX_WIDTH(MAX_WIDTH), .CONTEXTS(CONTEXTS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .width_i       (eff_width),
    .height_i      (eff_height),
    .pixel_valid_i (pixel_valid_i),
    .pixel_i       (pixel_i),
    .pixel_stall_o (pixel_stall_o),
    .push_o        (push),
    .code_o        (code_in),
    .full_i        (full)
  );

  // decouples the classify pipeline from the byte packer
  mgrpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (code_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (code_out),
    .empty_o (empty)
  );

  mgrpe_pack u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .valid_i     (!empty),
    .code_i      (code_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .plane_end_o (plane_end_o)
  );

endmodule
